@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LZWC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LZWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lzwc_pkg.sv @@
// Types, constants and the pair hash shared by the LZW compressor files.
`timescale 1ns / 1ps
`default_nettype none
package lzwc_pkg;

  localparam int HashBits = 16;
  localparam int HeadDepth = 1 << HashBits;
  localparam int FirstFree = 257;
  localparam int InitWidth = 9;

  localparam logic [7:0] HdrMagic0 = 8'h1f;
  localparam logic [7:0] HdrMagic1 = 8'h9d;
  localparam logic [7:0] HdrFlags  = 8'h90;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } lzwc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } lzwc_out_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HDR0,
    ST_HDR1,
    ST_HDR2,
    ST_DECIDE,
    ST_HEAD_WT,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_EMIT_LOAD,
    ST_EMIT_OUT,
    ST_ADD,
    ST_FLUSH_LOAD,
    ST_FLUSH_OUT,
    ST_PAD,
    ST_FIN
  } lzwc_state_e;

  typedef enum logic [2:0] {
    PUT_NONE,
    PUT_HDR0,
    PUT_HDR1,
    PUT_HDR2,
    PUT_ACC
  } lzwc_put_e;

  typedef struct packed {
    logic      clr_wr;
    logic      ld_in;
    lzwc_put_e put;
    logic      first;
    logic      head_rd;
    logic      probe_head;
    logic      probe_rd;
    logic      probe_next;
    logic      hit;
    logic      emit_load;
    logic      add;
    logic      cur_byte;
    logic      release_word;
    logic      restart;
  } lzwc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hdr_sent;
    logic have_cur;
    logic probe_zero;
    logic probe_match;
    logic tot_ge8;
    logic tot_nz;
    logic out_free;
    logic room;
    logic in_last;
  } lzwc_sts_t;

  // Hash of a (prefix, byte) pair into the chain head table.
  function automatic logic [HashBits-1:0] pair_hash(logic [15:0] prefix, logic [7:0] b);
    logic [15:0] m;
    m = (prefix << 5) - prefix;
    return m ^ {b, 8'h00} ^ {8'h00, b} ^ (prefix >> 9);
  endfunction

endpackage
`default_nettype wire

@@ design/lzwc_ctrl.sv @@
// Controller state machine of the LZW compressor.
`timescale 1ns / 1ps
`default_nettype none
module lzwc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lzwc_pkg::lzwc_sts_t sts_i,
  output lzwc_pkg::lzwc_cmd_t cmd_o
);
  import lzwc_pkg::*;

  lzwc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = sts_i.hdr_sent ? ST_DECIDE : ST_HDR0;
      end
      ST_HDR0: begin
        if (sts_i.out_free) state_d = ST_HDR1;
      end
      ST_HDR1: begin
        if (sts_i.out_free) state_d = ST_HDR2;
      end
      ST_HDR2: begin
        if (sts_i.out_free) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts_i.have_cur) state_d = sts_i.in_last ? ST_FLUSH_LOAD : ST_FIN;
        else state_d = ST_HEAD_WT;
      end
      ST_HEAD_WT: state_d = ST_PROBE_RD;
      ST_PROBE_RD: begin
        state_d = sts_i.probe_zero ? ST_EMIT_LOAD : ST_PROBE_CMP;
      end
      ST_PROBE_CMP: begin
        if (sts_i.probe_match) state_d = sts_i.in_last ? ST_FLUSH_LOAD : ST_FIN;
        else state_d = ST_PROBE_RD;
      end
      ST_EMIT_LOAD: state_d = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (!sts_i.tot_ge8) state_d = ST_ADD;
      end
      ST_ADD: state_d = sts_i.in_last ? ST_FLUSH_LOAD : ST_FIN;
      ST_FLUSH_LOAD: state_d = ST_FLUSH_OUT;
      ST_FLUSH_OUT: begin
        if (!sts_i.tot_ge8) state_d = ST_PAD;
      end
      ST_PAD: begin
        if (!sts_i.tot_nz || sts_i.out_free) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) state_d = sts_i.in_last ? ST_CLEAR : ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.ld_in  = in_valid_i;
      end
      ST_HDR0: if (sts_i.out_free) cmd_o.put = PUT_HDR0;
      ST_HDR1: if (sts_i.out_free) cmd_o.put = PUT_HDR1;
      ST_HDR2: if (sts_i.out_free) cmd_o.put = PUT_HDR2;
      ST_DECIDE: begin
        cmd_o.first   = !sts_i.have_cur;
        cmd_o.head_rd = sts_i.have_cur;
      end
      ST_HEAD_WT: cmd_o.probe_head = 1'b1;
      ST_PROBE_RD: cmd_o.probe_rd = !sts_i.probe_zero;
      ST_PROBE_CMP: begin
        cmd_o.hit        = sts_i.probe_match;
        cmd_o.probe_next = !sts_i.probe_match;
      end
      ST_EMIT_LOAD, ST_FLUSH_LOAD: cmd_o.emit_load = 1'b1;
      ST_EMIT_OUT, ST_FLUSH_OUT: begin
        if (sts_i.tot_ge8 && sts_i.out_free) cmd_o.put = PUT_ACC;
      end
      ST_ADD: begin
        cmd_o.add      = sts_i.room;
        cmd_o.cur_byte = 1'b1;
      end
      ST_PAD: if (sts_i.tot_nz && sts_i.out_free) cmd_o.put = PUT_ACC;
      ST_FIN: begin
        cmd_o.release_word = sts_i.out_free;
        cmd_o.restart      = sts_i.out_free && sts_i.in_last;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/lzwc_dp.sv @@
// Datapath of the LZW compressor: dictionary memories, bit packer, output stage.
`timescale 1ns / 1ps
`default_nettype none
module lzwc_dp #(
  parameter int MAX_CODE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzwc_pkg::lzwc_in_t  in_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output lzwc_pkg::lzwc_out_t out_data_o,
  input  lzwc_pkg::lzwc_cmd_t cmd_i,
  output lzwc_pkg::lzwc_sts_t sts_o
);
  import lzwc_pkg::*;

  localparam int CW    = MAX_CODE_BITS;
  localparam int Depth = 1 << CW;
  localparam int KW    = CW + 8;
  localparam int AccW  = CW + 7;
  localparam int TotW  = $clog2(AccW + 1);
  localparam int WW    = $clog2(CW + 1);

  logic [CW-1:0] head_mem  [HeadDepth];
  logic [KW-1:0] entry_mem [Depth];
  logic [CW-1:0] link_mem  [Depth];

  logic [CW-1:0] head_rd_q;
  logic [KW-1:0] ent_rd_q;
  logic [CW-1:0] link_rd_q;

  logic [7:0]          byte_q, byte_d;
  logic                last_q, last_d;
  logic [CW-1:0]       cur_q, cur_d;
  logic                have_q, have_d;
  logic [CW:0]         next_q, next_d;
  logic [WW-1:0]       width_q, width_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [TotW-1:0]     tot_q, tot_d;
  logic                hdr_q, hdr_d;
  logic [HashBits-1:0] h_q, h_d;
  logic [CW-1:0]       probe_q, probe_d;
  logic [HashBits-1:0] clr_q, clr_d;
  logic                hold_v_q, hold_v_d;
  logic [7:0]          hold_q, hold_d;
  logic                out_v_q, out_v_d;
  lzwc_out_t           out_q, out_d;

  logic [HashBits-1:0] hash_c;
  logic [CW:0]         one_w;
  logic [CW:0]         mask_w;
  logic [CW:0]         next_inc;
  logic [7:0]          put_byte;
  logic                head_we;
  logic [HashBits-1:0] head_wa;
  logic [CW-1:0]       head_wd;

  assign hash_c   = pair_hash(16'(cur_q), byte_q);
  assign one_w    = (CW + 1)'(1) << width_q;
  assign mask_w   = one_w - (CW + 1)'(1);
  assign next_inc = next_q + (CW + 1)'(1);

  assign head_we = cmd_i.clr_wr | cmd_i.add;
  assign head_wa = cmd_i.clr_wr ? clr_q : h_q;
  assign head_wd = cmd_i.clr_wr ? '0 : next_q[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (cmd_i.head_rd) head_rd_q <= head_mem[hash_c];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      entry_mem[next_q[CW-1:0]] <= {cur_q, byte_q};
      link_mem[next_q[CW-1:0]]  <= head_rd_q;
    end
    if (cmd_i.probe_rd) begin
      ent_rd_q  <= entry_mem[probe_q];
      link_rd_q <= link_mem[probe_q];
    end
  end

  always_comb begin
    case (cmd_i.put)
      PUT_HDR0: put_byte = HdrMagic0;
      PUT_HDR1: put_byte = HdrMagic1;
      PUT_HDR2: put_byte = HdrFlags;
      default:  put_byte = acc_q[7:0];
    endcase
  end

  always_comb begin
    byte_d   = byte_q;
    last_d   = last_q;
    cur_d    = cur_q;
    have_d   = have_q;
    next_d   = next_q;
    width_d  = width_q;
    acc_d    = acc_q;
    tot_d    = tot_q;
    hdr_d    = hdr_q;
    h_d      = h_q;
    probe_d  = probe_q;
    clr_d    = clr_q;
    hold_v_d = hold_v_q;
    hold_d   = hold_q;
    out_v_d  = out_v_q && out_stall_i;
    out_d    = out_q;

    if (cmd_i.clr_wr) clr_d = clr_q + HashBits'(1);
    if (cmd_i.ld_in) begin
      byte_d = in_data_i.data_byte;
      last_d = in_data_i.end_of_input;
    end
    if (cmd_i.first) begin
      cur_d  = CW'(byte_q);
      have_d = 1'b1;
    end
    if (cmd_i.head_rd) h_d = hash_c;
    if (cmd_i.probe_head) probe_d = head_rd_q;
    if (cmd_i.probe_next) probe_d = link_rd_q;
    if (cmd_i.hit) cur_d = probe_q;
    if (cmd_i.emit_load) begin
      acc_d = acc_q | (AccW'(cur_q & mask_w[CW-1:0]) << tot_q);
      tot_d = tot_q + TotW'(width_q);
    end
    if (cmd_i.add) begin
      next_d = next_inc;
      if ((next_inc > one_w) && (width_q < WW'(CW))) width_d = width_q + WW'(1);
    end
    if (cmd_i.cur_byte) cur_d = CW'(byte_q);

    // Stage each new word in the hold slot so the last word of an item can be tagged.
    if (cmd_i.put != PUT_NONE) begin
      if (hold_v_q) begin
        out_v_d = 1'b1;
        out_d   = '{out_byte: hold_q, last_of_run: 1'b0};
      end
      hold_v_d = 1'b1;
      hold_d   = put_byte;
      if (cmd_i.put == PUT_HDR2) hdr_d = 1'b1;
      if (cmd_i.put == PUT_ACC) begin
        acc_d = acc_q >> 8;
        tot_d = tot_q - TotW'(8);
      end
    end
    if (cmd_i.release_word && hold_v_q) begin
      out_v_d  = 1'b1;
      out_d    = '{out_byte: hold_q, last_of_run: 1'b1};
      hold_v_d = 1'b0;
    end
    if (cmd_i.restart) begin
      have_d  = 1'b0;
      next_d  = (CW + 1)'(FirstFree);
      width_d = WW'(InitWidth);
      acc_d   = '0;
      tot_d   = '0;
      hdr_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      next_q   <= (CW + 1)'(FirstFree);
      width_q  <= WW'(InitWidth);
      acc_q    <= '0;
      tot_q    <= '0;
      hdr_q    <= 1'b0;
      clr_q    <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      have_q   <= have_d;
      next_q   <= next_d;
      width_q  <= width_d;
      acc_q    <= acc_d;
      tot_q    <= tot_d;
      hdr_q    <= hdr_d;
      clr_q    <= clr_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    last_q  <= last_d;
    cur_q   <= cur_d;
    h_q     <= h_d;
    probe_q <= probe_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign sts_o.clr_last    = (clr_q == '1);
  assign sts_o.hdr_sent    = hdr_q;
  assign sts_o.have_cur    = have_q;
  assign sts_o.probe_zero  = (probe_q == '0);
  assign sts_o.probe_match = (ent_rd_q == {cur_q, byte_q});
  assign sts_o.tot_ge8     = (tot_q >= TotW'(8));
  assign sts_o.tot_nz      = (tot_q != '0);
  assign sts_o.out_free    = !out_v_q || !out_stall_i;
  assign sts_o.room        = !next_q[CW];
  assign sts_o.in_last     = last_q;

endmodule
`default_nettype wire

@@ design/lzw_compress_variable_width.sv @@
// Top level of the LZW compressor (unix compress style, variable code width).
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | in_valid_i / in_stall_o   | lzwc_in_t  {data_byte, end_of_input}
//  out     | output    | out_valid_o / out_stall_i | lzwc_out_t {out_byte, last_of_run}
//
// One input word at a time. A stream's first byte only becomes the current code; a later
// word probes its hash chain entry by entry: a hit stops the walk, a miss emits the code
// and adds an entry while codes are left. The header leads each stream; end_of_input
// adds a flush and a pad. After reset and after each end_of_input word the chain head
// table is swept, one entry a cycle; no input word is taken during the sweep.
// A stalled output holds its word; the core holds while the output slot is full and stalled.
`timescale 1ns / 1ps
`default_nettype none
module lzw_compress_variable_width #(
  parameter int MAX_CODE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lzwc_pkg::lzwc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lzwc_pkg::lzwc_out_t out_data_o
);
  import lzwc_pkg::*;

  // Commands from the controller, status back from the datapath.
  lzwc_cmd_t cmd;
  lzwc_sts_t sts;

  // Sequence header, lookup, emit, add and flush for each input word.
  lzwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the dictionary, the current code, the bit packer and the output register.
  lzwc_dp #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

@@ design/lzwc_checker.sv @@
// Port-level checker for the LZW compressor and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lzwc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input lzwc_pkg::lzwc_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lzwc_pkg::lzwc_out_t out_data_o
);
  import lzwc_pkg::*;

  // A stalled input word holds.
  `LZWC_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_data_i), "stalled input word changed")

  // A stalled output word holds.
  `LZWC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output word changed")

  // An accepted word keeps the core busy for at least the next cycle.
  `LZWC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input taken twice in a row")

  // The last word of an item leaves nothing behind in the output slot.
  `LZWC_ASSERT_NEXT(a_last_drains, out_valid_o && !out_stall_i && out_data_o.last_of_run, !out_valid_o, "word followed last of run at once")

endmodule

bind lzw_compress_variable_width lzwc_checker u_lzwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

@@ dv/tb_lzw_compress_variable_width.sv @@
// Testbench for the variable-width LZW compressor, self-checking against its own predictor.
`timescale 1ns / 1ps
module tb_lzw_compress_variable_width;
  import lzwc_pkg::*;

  // The block sweeps its 64K-entry hash head table after reset and after every
  // end_of_input word, so each stream is followed by a sweep. Seven sweeps plus
  // the traffic of the tests fit well inside this limit.
  localparam int CycleLimit = 2_000_000;
  localparam int DrainCycles = 64;
  localparam int MaxCodeBits = 16;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  lzwc_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  lzwc_out_t out_data_o;

  lzw_compress_variable_width #(
    .MAX_CODE_BITS(MaxCodeBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Expected output words, oldest first.
  lzwc_out_t expected_words[$];
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;

  // Idle control: quiet turns off all random gaps; a flip of hold_off_tgl makes
  // the receiver stall while a count loaded from hold_off_len runs down.
  bit        quiet;
  bit        sender_eager;
  int        hold_off_len;
  bit        hold_off_tgl;

  // Compressor state mirrored by the predictor.
  int        code_of_pair[int];
  logic [15:0] cur_code;
  bit          have_cur;
  logic [16:0] next_free;
  int          code_bits;
  logic [6:0]  pend_bits;
  int          pend_cnt;
  bit          hdr_done;
  lzwc_out_t   word_batch[$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic clear_compressor();
    code_of_pair.delete();
    cur_code  = '0;
    have_cur  = 1'b0;
    next_free = 17'd257;
    code_bits = 9;
    pend_bits = '0;
    pend_cnt  = 0;
    hdr_done  = 1'b0;
  endtask

  task automatic put_word(logic [7:0] b);
    lzwc_out_t w;
    if (word_batch.size() < 8) begin
      w.out_byte    = b;
      w.last_of_run = 1'b0;
      word_batch    = {word_batch, w};
    end
  endtask

  // Pack one code LSB-first behind the pending bits.
  task automatic pack_code(logic [15:0] code);
    logic [63:0] acc;
    int          total;
    acc   = 64'(pend_bits) | ((64'(code) & ((64'd1 << code_bits) - 1)) << pend_cnt);
    total = pend_cnt + code_bits;
    while (total >= 8) begin
      put_word(acc[7:0]);
      acc   = acc >> 8;
      total -= 8;
    end
    pend_bits = acc[6:0];
    pend_cnt  = total;
  endtask

  // Work out the output words of one accepted input word.
  task automatic compress_word(lzwc_in_t item);
    int key;
    word_batch.delete();
    if (!hdr_done) begin
      put_word(HdrMagic0);
      put_word(HdrMagic1);
      put_word(HdrFlags);
      hdr_done = 1'b1;
    end
    if (!have_cur) begin
      // first byte of a stream only becomes the current string
      cur_code = 16'(item.data_byte);
      have_cur = 1'b1;
    end else begin
      key = (int'(cur_code) << 8) | int'(item.data_byte);
      if (code_of_pair.exists(key)) begin
        cur_code = 16'(code_of_pair[key]);
      end else begin
        pack_code(cur_code);
        // stop adding once the code space is used up; width then stays put
        if (next_free < (17'd1 << MaxCodeBits)) begin
          code_of_pair[key] = int'(next_free);
          next_free++;
          if (next_free > (17'd1 << code_bits) && code_bits < MaxCodeBits) code_bits++;
        end
        cur_code = 16'(item.data_byte);
      end
    end
    if (item.end_of_input) begin
      pack_code(cur_code);
      if (pend_cnt != 0) put_word(8'(pend_bits));
      clear_compressor();
    end
    if (word_batch.size() > 0) word_batch[word_batch.size() - 1].last_of_run = 1'b1;
    foreach (word_batch[i]) expected_words = {expected_words, word_batch[i]};
  endtask

  // Offer one input word after a random gap; advance on acceptance.
  task automatic send_word(logic [7:0] b, bit eoi);
    int gap;
    gap = (quiet || sender_eager) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_data_i.data_byte    <= b;
    in_data_i.end_of_input <= eoi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    compress_word('{data_byte: b, end_of_input: eoi});
  endtask

  // Random stream; a narrow alphabet makes long dictionary hits likely.
  task automatic send_stream(int len, bit narrow);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = narrow ? 8'($urandom_range(0, 3)) << $urandom_range(0, 6) : 8'($urandom);
      send_word(b, i == len - 1);
    end
  endtask

  // Drop the input and wait until every expected word has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Header, one code and a padded byte from a single-word stream.
  task automatic test_single_byte();
    send_word(8'h00, 1'b1);
    wait_drained();
  endtask

  // Runs of equal bytes grow hit chains; extremes of the byte field.
  task automatic test_repeats();
    logic [7:0] seq[] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff,
                          8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h01, 8'h80,
                          8'h7f, 8'hfe, 8'h00, 8'h00, 8'h00};
    quiet = 1'b1;
    foreach (seq[i]) send_word(seq[i], i == seq.size() - 1);
    quiet = 1'b0;
    wait_drained();
  endtask

  // Hold the output off while the sender keeps pushing, so the block backs up.
  task automatic test_backpressure();
    sender_eager = 1'b1;
    hold_off_len = 400;
    hold_off_tgl = !hold_off_tgl;
    send_stream(20, 1'b0);
    sender_eager = 1'b0;
    wait_drained();
  endtask

  // Streams over a wide, a narrow and a randomly chosen alphabet.
  task automatic test_random_streams();
    send_stream(30, 1'b0);
    wait_drained();
    send_stream(15, 1'b1);
    wait_drained();
    send_stream(12, 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  // Check each accepted output word and drive the receiver stall.
  int  rx_wait;
  int  rx_draw;
  bit  rx_take;
  int  hold_left;
  bit  hold_seen;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      rx_wait     <= 0;
      hold_left   <= 0;
      hold_seen   <= 1'b0;
    end else begin
      rx_take = out_valid_o && !out_stall_i;
      if (rx_take) begin
        if (expected_words.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected no word, got byte %h last %b",
                     out_data_o.out_byte, out_data_o.last_of_run);
        end else begin
          if (out_data_o.out_byte !== expected_words[0].out_byte ||
              out_data_o.last_of_run !== expected_words[0].last_of_run) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected byte %h last %b, got byte %h last %b",
                       expected_words[0].out_byte, expected_words[0].last_of_run,
                       out_data_o.out_byte, out_data_o.last_of_run);
          end
          void'(expected_words.pop_front());
        end
      end
      if (hold_seen != hold_off_tgl) begin
        hold_seen   <= hold_off_tgl;
        hold_left   <= hold_off_len;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (rx_take) begin
        rx_draw = quiet ? 0 : $urandom_range(0, 15);
        rx_wait     <= rx_draw;
        out_stall_i <= (rx_draw != 0);
      end else if (rx_wait > 0) begin
        out_stall_i <= (rx_wait > 1);
        rx_wait     <= rx_wait - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Abort on a hang.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    quiet        = 1'b0;
    sender_eager = 1'b0;
    hold_off_len = 0;
    hold_off_tgl = 1'b0;
    clear_compressor();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_single_byte();
    test_repeats();
    test_backpressure();
    test_random_streams();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/lzwc_pkg.sv
design/lzwc_ctrl.sv
design/lzwc_dp.sv
design/lzw_compress_variable_width.sv
design/lzwc_checker.sv
dv/tb_lzw_compress_variable_width.sv
